/* rtl/act_pkg.sv */
// Shared types, codes and the box overlap test for the box collider table.
package act_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 32;
  localparam int unsigned ID_W                = 10;
  localparam int unsigned COORD_W             = 32;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXISTS    = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    box_t            box;
  } entry_t;

  // Inclusive overlap on all three axes; inverted boxes are compared as given.
  function automatic logic boxes_overlap(box_t q, box_t s);
    logic ox, oy, oz;
    ox = ($signed(q.min_x) <= $signed(s.max_x)) && ($signed(q.max_x) >= $signed(s.min_x));
    oy = ($signed(q.min_y) <= $signed(s.max_y)) && ($signed(q.max_y) >= $signed(s.min_y));
    oz = ($signed(q.min_z) <= $signed(s.max_z)) && ($signed(q.max_z) >= $signed(s.min_z));
    return ox && oy && oz;
  endfunction

endpackage

/* rtl/act_ram.sv */
// Entry storage: one write port, one read port, registered read data.
module act_ram import act_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int unsigned IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/aabb_collider_table_top.sv */
// Box collider table: compacted box store with add, remove, replace and overlap query.
//
// Usage: present a command on operation_i, box_id_i and the six extents and
// raise start; the beat is taken on a rising edge where start is high and
// busy is low. Results come back on the result ports, each valid for exactly
// one cycle while result_valid_o is high; last_o marks the final result of a
// command. Add, remove and replace give one result; a query gives one result
// per overlapping stored box whose id differs from its own, in table order,
// then a summary with any_hit_o. Every command walks the stored entries
// through the entry memory, one read per cycle. The next command can be taken
// at the edge that ends the cycle of a command's final result. A remove of the
// entry at position p also moves the n - p - 1 entries above it down, one per
// cycle, where n is the number of stored boxes. Reset empties the table at
// once; no clearing pass runs. The receiver cannot hold results off, so
// results are never delayed.
module aabb_collider_table_top import act_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int unsigned IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                operation_i,
  input  logic [ID_W-1:0]           box_id_i,
  input  logic signed [COORD_W-1:0] min_x_i,
  input  logic signed [COORD_W-1:0] min_y_i,
  input  logic signed [COORD_W-1:0] min_z_i,
  input  logic signed [COORD_W-1:0] max_x_i,
  input  logic signed [COORD_W-1:0] max_y_i,
  input  logic signed [COORD_W-1:0] max_z_i,
  output logic                      result_valid_o,
  output logic [1:0]                status_o,
  output logic [CNT_W-1:0]          entry_total_o,
  output logic                      hit_valid_o,
  output logic [ID_W-1:0]           hit_id_o,
  output logic                      any_hit_o,
  output logic                      last_o
);

  state_e           state_q, state_d;
  op_e              op_q;
  logic [ID_W-1:0]  id_q;
  box_t             box_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             any_q, any_d;

  logic             res_vld_q, res_vld_d;
  status_e          res_status_q, res_status_d;
  logic [CNT_W-1:0] res_total_q, res_total_d;
  logic             res_hv_q, res_hv_d;
  logic [ID_W-1:0]  res_hid_q, res_hid_d;
  logic             res_any_q, res_any_d;
  logic             res_last_q, res_last_d;

  logic             accept;
  logic             rd_more;
  logic             scan_done;
  logic             ram_re, ram_we;
  logic [IDX_W-1:0] ram_raddr, ram_waddr;
  entry_t           ram_wdata, ram_rdata;

  act_ram #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign accept    = start && (state_q == S_IDLE);
  assign rd_more   = (rd_idx_q < cnt_q);
  assign scan_done = !rd_more && !chk_vld_q;
  assign ram_raddr = rd_idx_q[IDX_W-1:0];

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_idx_d     = rd_idx_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    found_d      = found_q;
    pos_d        = pos_q;
    any_d        = any_q;
    res_vld_d    = 1'b0;
    res_status_d = ST_OK;
    res_total_d  = cnt_q;
    res_hv_d     = 1'b0;
    res_hid_d    = '0;
    res_any_d    = 1'b0;
    res_last_d   = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '{id: id_q, box: box_q};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d  = S_SCAN;
          rd_idx_d = '0;
          found_d  = 1'b0;
          any_d    = 1'b0;
        end
      end

      S_SCAN: begin
        if (rd_more) begin
          ram_re    = 1'b1;
          rd_idx_d  = rd_idx_q + CNT_W'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q[IDX_W-1:0];
        end
        if (chk_vld_q) begin
          if (ram_rdata.id == id_q) begin
            found_d = 1'b1;
            pos_d   = chk_idx_q;
          end else if (op_q == OP_QUERY && boxes_overlap(box_q, ram_rdata.box)) begin
            res_vld_d = 1'b1;
            res_hv_d  = 1'b1;
            res_hid_d = ram_rdata.id;
            any_d     = 1'b1;
          end
        end
        if (scan_done) begin
          res_vld_d  = 1'b1;
          res_last_d = 1'b1;
          state_d    = S_IDLE;
          case (op_q)
            OP_ADD: begin
              if (found_q) begin
                res_status_d = ST_EXISTS;
              end else if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = cnt_q[IDX_W-1:0];
                cnt_d       = cnt_q + CNT_W'(1);
                res_total_d = cnt_q + CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              if (!found_q) begin
                res_status_d = ST_NOT_FOUND;
              end else begin
                // Compact the table before reporting.
                res_vld_d  = 1'b0;
                res_last_d = 1'b0;
                state_d    = S_SHIFT;
                rd_idx_d   = CNT_W'(pos_q) + CNT_W'(1);
              end
            end
            OP_REPLACE: begin
              if (found_q) begin
                ram_we    = 1'b1;
                ram_waddr = pos_q;
              end else begin
                res_status_d = ST_NOT_FOUND;
              end
            end
            OP_QUERY: begin
              res_any_d = any_q;
            end
            default: begin
              res_status_d = ST_OK;
            end
          endcase
        end
      end

      S_SHIFT: begin
        if (rd_more) begin
          ram_re    = 1'b1;
          rd_idx_d  = rd_idx_q + CNT_W'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q[IDX_W-1:0];
        end
        // Each entry read above the removed one lands one slot lower.
        if (chk_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = chk_idx_q - IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        if (scan_done) begin
          cnt_d       = cnt_q - CNT_W'(1);
          res_total_d = cnt_q - CNT_W'(1);
          res_vld_d   = 1'b1;
          res_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_idx_q  <= '0;
      chk_vld_q <= 1'b0;
      found_q   <= 1'b0;
      any_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_idx_q  <= rd_idx_d;
      chk_vld_q <= chk_vld_d;
      found_q   <= found_d;
      any_q     <= any_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q            <= op_e'(operation_i);
      id_q            <= box_id_i;
      box_q.min_x     <= min_x_i;
      box_q.min_y     <= min_y_i;
      box_q.min_z     <= min_z_i;
      box_q.max_x     <= max_x_i;
      box_q.max_y     <= max_y_i;
      box_q.max_z     <= max_z_i;
    end
    chk_idx_q    <= chk_idx_d;
    pos_q        <= pos_d;
    res_status_q <= res_status_d;
    res_total_q  <= res_total_d;
    res_hv_q     <= res_hv_d;
    res_hid_q    <= res_hid_d;
    res_any_q    <= res_any_d;
    res_last_q   <= res_last_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign status_o       = res_status_q;
  assign entry_total_o  = res_total_q;
  assign hit_valid_o    = res_hv_q;
  assign hit_id_o       = res_hid_q;
  assign any_hit_o      = res_any_q;
  assign last_o         = res_last_q;

  // The stored count only moves together with the final result beat of a command.
  a_cnt_moves_with_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (result_valid_o && last_o))
    else $error("stored count changed without a final result beat");

  // A final result beat means the block is free for the next command.
  a_final_frees_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy)
    else $error("final result shown while the block is still busy");

  // An accepted command always makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not start work");

  // Hit beats only come from a running query and never close it.
  a_hit_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_valid_o) |-> (!last_o && busy && op_q == OP_QUERY))
    else $error("hit beat outside a running query");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (cnt_q <= CNT_W'(TABLE_DEPTH)))
    else $error("stored count beyond table depth");

endmodule

/* tb/aabb_collider_table_top_tb.sv */
// Self-checking testbench for the box collider table: directed, full-table and random traffic.
module aabb_collider_table_top_tb;
  import act_pkg::*;

  localparam int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int          TAIL_CYCLES = 80;
  localparam coord_t      COORD_MIN   = 32'sh8000_0000;
  localparam coord_t      COORD_MAX   = 32'sh7fff_ffff;
  localparam coord_t      ONE         = 32'sh0001_0000;
  localparam box_t        WHOLE_SPACE = '{COORD_MIN, COORD_MIN, COORD_MIN,
                                          COORD_MAX, COORD_MAX, COORD_MAX};

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] total;
    logic             hit;
    logic [ID_W-1:0]  hit_id;
    logic             any;
    logic             last;
  } outcome_t;

  logic                      clk_i;
  logic                      rst_ni      = 1'b0;
  logic                      start       = 1'b0;
  logic                      busy;
  logic [1:0]                operation_i = '0;
  logic [ID_W-1:0]           box_id_i    = '0;
  logic signed [COORD_W-1:0] min_x_i     = '0;
  logic signed [COORD_W-1:0] min_y_i     = '0;
  logic signed [COORD_W-1:0] min_z_i     = '0;
  logic signed [COORD_W-1:0] max_x_i     = '0;
  logic signed [COORD_W-1:0] max_y_i     = '0;
  logic signed [COORD_W-1:0] max_z_i     = '0;
  logic                      result_valid_o;
  logic [1:0]                status_o;
  logic [CNT_W-1:0]          entry_total_o;
  logic                      hit_valid_o;
  logic [ID_W-1:0]           hit_id_o;
  logic                      any_hit_o;
  logic                      last_o;

  // Shadow copy of the box table and the results it predicts.
  logic [ID_W-1:0] table_ids   [TABLE_DEPTH];
  box_t            table_boxes [TABLE_DEPTH];
  int              table_fill = 0;
  outcome_t        awaited_results [$];
  int              error_count = 0;
  int              sender_idle_pct = 0;

  aabb_collider_table_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .box_id_i       (box_id_i),
    .min_x_i        (min_x_i),
    .min_y_i        (min_y_i),
    .min_z_i        (min_z_i),
    .max_x_i        (max_x_i),
    .max_y_i        (max_y_i),
    .max_z_i        (max_z_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .entry_total_o  (entry_total_o),
    .hit_valid_o    (hit_valid_o),
    .hit_id_o       (hit_id_o),
    .any_hit_o      (any_hit_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("aabb_collider_table_top_tb: done, errors");
    $finish;
  end

  function automatic int find_entry(logic [ID_W-1:0] id);
    int k;
    for (k = 0; k < table_fill; k++) begin
      if (table_ids[k] == id) return k;
    end
    return -1;
  endfunction

  // Appends one predicted result beat to the tail of the queue.
  function automatic void enqueue_result(outcome_t o);
    awaited_results = {awaited_results, o};
  endfunction

  // Updates the shadow table for one accepted beat and queues its results.
  function automatic void apply_command(op_e op, logic [ID_W-1:0] id, box_t box);
    int       pos;
    int       k;
    int       axis;
    logic     hit;
    logic     any;
    coord_t   ql, qh, sl, sh;
    outcome_t r;
    pos = find_entry(id);
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    case (op)
      OP_ADD: begin
        if (pos >= 0) begin
          r.status = ST_EXISTS;
        end else if (table_fill == TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          table_ids[table_fill] = id;
          table_boxes[table_fill] = box;
          table_fill++;
        end
      end
      OP_REMOVE: begin
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (k = pos; k < table_fill - 1; k++) begin
            table_ids[k] = table_ids[k + 1];
            table_boxes[k] = table_boxes[k + 1];
          end
          table_fill--;
        end
      end
      OP_REPLACE: begin
        if (pos < 0) r.status = ST_NOT_FOUND;
        else table_boxes[pos] = box;
      end
      default: begin
        any = 1'b0;
        for (k = 0; k < table_fill; k++) begin
          if (table_ids[k] != id) begin
            hit = 1'b1;
            for (axis = 0; axis < 3; axis++) begin
              case (axis)
                0: begin
                  ql = box.min_x; qh = box.max_x;
                  sl = table_boxes[k].min_x; sh = table_boxes[k].max_x;
                end
                1: begin
                  ql = box.min_y; qh = box.max_y;
                  sl = table_boxes[k].min_y; sh = table_boxes[k].max_y;
                end
                default: begin
                  ql = box.min_z; qh = box.max_z;
                  sl = table_boxes[k].min_z; sh = table_boxes[k].max_z;
                end
              endcase
              if (ql > sh || qh < sl) hit = 1'b0;
            end
            if (hit) begin
              outcome_t h;
              h = '0;
              h.status = ST_OK;
              h.total = CNT_W'(table_fill);
              h.hit = 1'b1;
              h.hit_id = table_ids[k];
              enqueue_result(h);
              any = 1'b1;
            end
          end
        end
        r.any = any;
      end
    endcase
    r.total = CNT_W'(table_fill);
    enqueue_result(r);
  endfunction

  function automatic void note_mismatch(string what, outcome_t seen, outcome_t want,
                                        bit has_want);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t %s: got status %0d total %0d hit %0b id %0d any %0b last %0b",
               $realtime, what, seen.status, seen.total, seen.hit, seen.hit_id,
               seen.any, seen.last);
      if (has_want)
        $display("  expected status %0d total %0d hit %0b id %0d any %0b last %0b",
                 want.status, want.total, want.hit, want.hit_id, want.any, want.last);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    outcome_t seen;
    outcome_t want;
    if (rst_ni && result_valid_o) begin
      seen.status = status_e'(status_o);
      seen.total  = entry_total_o;
      seen.hit    = hit_valid_o;
      seen.hit_id = hit_id_o;
      seen.any    = any_hit_o;
      seen.last   = last_o;
      if (awaited_results.size() == 0) begin
        note_mismatch("result beat with nothing outstanding", seen, seen, 1'b0);
      end else begin
        want = awaited_results.pop_front();
        if (seen.status !== want.status || seen.total !== want.total ||
            seen.hit !== want.hit || seen.hit_id !== want.hit_id ||
            seen.any !== want.any || seen.last !== want.last)
          note_mismatch("result beat mismatch", seen, want, 1'b1);
      end
    end
  end

  function automatic box_t make_cube(coord_t lo, coord_t hi);
    box_t b;
    b = '{lo, lo, lo, hi, hi, hi};
    return b;
  endfunction

  // Mostly small boxes near the origin so that overlaps are common, with some
  // full-range, extreme and inverted ones.
  function automatic box_t random_box();
    coord_t lo [3];
    coord_t hi [3];
    coord_t picks [6];
    int     mode;
    int     axis;
    picks = '{COORD_MIN, COORD_MIN + 1, -1, 0, COORD_MAX - 1, COORD_MAX};
    mode = $urandom_range(0, 9);
    for (axis = 0; axis < 3; axis++) begin
      if (mode == 0) begin
        lo[axis] = $urandom;
        hi[axis] = $urandom;
      end else if (mode == 1) begin
        lo[axis] = picks[$urandom_range(0, 5)];
        hi[axis] = picks[$urandom_range(0, 5)];
      end else begin
        lo[axis] = (int'($urandom_range(0, 48)) - 24) * ONE;
        if ($urandom_range(0, 1) == 1) lo[axis] = lo[axis] + int'($urandom_range(0, 65535));
        if ($urandom_range(0, 19) == 0)
          hi[axis] = lo[axis] - int'($urandom_range(1, 4 * 65536));
        else
          hi[axis] = lo[axis] + int'($urandom_range(0, 12)) * ONE;
      end
    end
    return '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
  endfunction

  function automatic logic [ID_W-1:0] pick_id(int known_pct);
    int r;
    r = $urandom_range(0, 99);
    if (table_fill > 0 && r < known_pct) return table_ids[$urandom_range(0, table_fill - 1)];
    if ($urandom_range(0, 3) != 0) return ID_W'($urandom_range(0, 63));
    return ID_W'($urandom_range(0, 1023));
  endfunction

  // Presents one command beat; start stays high on return so that a following
  // beat can go out without a gap.
  task automatic send_command(op_e op, logic [ID_W-1:0] id, box_t box);
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 40)) @(negedge clk_i);
      while ($urandom_range(0, 99) < sender_idle_pct) @(negedge clk_i);
    end
    @(negedge clk_i);
    start       <= 1'b1;
    operation_i <= op;
    box_id_i    <= id;
    min_x_i     <= box.min_x;
    min_y_i     <= box.min_y;
    min_z_i     <= box.min_z;
    max_x_i     <= box.max_x;
    max_y_i     <= box.max_y;
    max_z_i     <= box.max_z;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apply_command(op, id, box);
  endtask

  task automatic settle_table(int extra_cycles);
    @(negedge clk_i);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (extra_cycles) @(posedge clk_i);
  endtask

  task automatic test_basic_commands();
    box_t b;
    send_command(OP_QUERY, 10'd7, WHOLE_SPACE);
    send_command(OP_REMOVE, 10'd3, make_cube(0, ONE));
    send_command(OP_REPLACE, 10'd3, make_cube(0, ONE));
    send_command(OP_ADD, 10'd0, WHOLE_SPACE);
    send_command(OP_ADD, 10'd1023, make_cube(0, ONE));
    send_command(OP_ADD, 10'd0, make_cube(0, ONE));
    send_command(OP_ADD, 10'd512, make_cube(ONE, 2 * ONE));
    // A stored id skips its own entry; touching faces count as overlap.
    send_command(OP_QUERY, 10'd1023, make_cube(0, ONE));
    send_command(OP_QUERY, 10'd99, make_cube(2 * ONE, 3 * ONE));
    send_command(OP_QUERY, 10'd99, make_cube(2 * ONE + 1, 3 * ONE));
    send_command(OP_QUERY, 10'd98, make_cube(3 * ONE, -3 * ONE));
    send_command(OP_QUERY, 10'd0, WHOLE_SPACE);
    send_command(OP_REPLACE, 10'd1023, make_cube(COORD_MAX - 1, COORD_MAX));
    send_command(OP_QUERY, 10'd5, make_cube(COORD_MAX, COORD_MAX));
    send_command(OP_QUERY, 10'd5, make_cube(COORD_MIN, COORD_MIN));
    send_command(OP_REMOVE, 10'd0, WHOLE_SPACE);
    send_command(OP_QUERY, 10'd5, WHOLE_SPACE);
    send_command(OP_REMOVE, 10'd512, WHOLE_SPACE);
    send_command(OP_ADD, 10'd0, make_cube(-ONE, ONE));
    b = make_cube(0, ONE);
    b.min_z = 5 * ONE;
    b.max_z = 6 * ONE;
    send_command(OP_QUERY, 10'd5, b);
    send_command(OP_REMOVE, 10'd1023, WHOLE_SPACE);
    settle_table(8);
  endtask

  task automatic test_full_table();
    logic [ID_W-1:0] id;
    while (table_fill < TABLE_DEPTH) begin
      id = ID_W'($urandom_range(0, 1023));
      if (find_entry(id) < 0) begin
        send_command(OP_ADD, id, random_box());
        if ($urandom_range(0, 5) == 0) send_command(OP_QUERY, pick_id(50), random_box());
      end
    end
    do id = ID_W'($urandom_range(0, 1023)); while (find_entry(id) >= 0);
    send_command(OP_ADD, id, random_box());
    // The duplicate check wins over the full check.
    send_command(OP_ADD, table_ids[5], random_box());
    send_command(OP_QUERY, id, WHOLE_SPACE);
    send_command(OP_QUERY, table_ids[TABLE_DEPTH - 1], WHOLE_SPACE);
    send_command(OP_REPLACE, table_ids[16], WHOLE_SPACE);
    send_command(OP_QUERY, id, random_box());
    send_command(OP_REMOVE, table_ids[0], random_box());
    send_command(OP_ADD, id, random_box());
    send_command(OP_REMOVE, table_ids[TABLE_DEPTH - 1], random_box());
    send_command(OP_REMOVE, table_ids[13], random_box());
    send_command(OP_QUERY, id, WHOLE_SPACE);
    settle_table(8);
  endtask

  task automatic test_random_traffic(int items);
    int   n;
    int   r;
    bit   filling;
    op_e  op;
    box_t box;
    filling = 1'b1;
    for (n = 0; n < items; n++) begin
      if (table_fill <= 1) filling = 1'b1;
      else if (table_fill == TABLE_DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_QUERY;
      else if (r < (filling ? 70 : 42)) op = OP_ADD;
      else if (r < 80) op = OP_REMOVE;
      else op = OP_REPLACE;
      box = ($urandom_range(0, 15) == 0) ? WHOLE_SPACE : random_box();
      send_command(op, pick_id(op == OP_ADD ? 15 : 70), box);
      if ($urandom_range(0, 49) == 0) settle_table(0);
    end
    settle_table(8);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    sender_idle_pct = 28;
    test_basic_commands();
    test_full_table();
    test_random_traffic(140);
    sender_idle_pct = 62;
    test_random_traffic(140);
    sender_idle_pct = 0;
    test_random_traffic(140);
    settle_table(TAIL_CYCLES);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("aabb_collider_table_top_tb: done, clean");
    end else begin
      $display("aabb_collider_table_top_tb: done, errors");
    end
    $finish;
  end

endmodule
